[rtl/tscr_pkg.sv]
`default_nettype none

package tscr_pkg;

    localparam int MAX_DIM       = 7;
    localparam int MAX_PIECES    = 10;

    localparam int WORD_W        = 64;
    localparam int DIM_W         = 3;
    localparam int PC_W          = 4;
    localparam int CFG_DATA_W    = 4;
    localparam int POS_W         = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int ORD_W         = $clog2(MAX_PIECES + 2);
    localparam int COL_W         = 3;

    localparam int BOARD_ORIGIN  = 9;
    localparam int ROW_STRIDE    = 8;
    localparam int SR_W          = WORD_W - BOARD_ORIGIN;

    localparam int DIGIT_W       = 8;
    localparam int MUL_STEPS     = WORD_W / DIGIT_W;
    localparam int MUL_CNT_W     = $clog2(MUL_STEPS);

    typedef enum logic [0:0] {
        CFG_BOARD_DIM   = 1'b0,
        CFG_PIECE_COUNT = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MULT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic advance;
    } row_ctrl_t;

endpackage

`default_nettype wire

[rtl/two_set_combinadic_ranker.sv]
`default_nettype none

// The block takes no new item until it is done with the last one: it scans the
// board one cell per cycle, then runs the eight-step byte-serial multiply.
// The output register frees the input side while a result waits for transfer.
// Reset (rst_n, asynchronous, active low) idles the block, empties the output
// and sets board_dim to 7 and piece_count to 10.
module two_set_combinadic_ranker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             cfg_we,
    input  wire tscr_pkg::cfg_index_t             cfg_index,
    input  wire logic [tscr_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [tscr_pkg::WORD_W-1:0]      player_board,
    input  wire logic [tscr_pkg::WORD_W-1:0]      opponent_board,

    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic      [tscr_pkg::WORD_W-1:0]      state_rank
);
    import tscr_pkg::*;

    // Configuration registers.
    logic [DIM_W-1:0]     board_dim_reg;
    logic [PC_W-1:0]      piece_count_reg;

    // Sequencer and scan counters.
    state_t               state_reg, state_next;
    logic [POS_W-1:0]     pos_reg;
    logic [COL_W-1:0]     col_reg;
    logic [ORD_W-1:0]     ord_pl_reg;
    logic [ORD_W-1:0]     ord_op_reg;
    logic                 op_merge_reg;
    logic [MUL_CNT_W-1:0] mul_cnt_reg;
    logic                 out_valid_reg;

    // Datapath. The boards shift down one row per board row; the rank
    // registers are reused as multiplicand and accumulator in the multiply.
    logic [SR_W-1:0]      sr_pl_reg;
    logic [SR_W-1:0]      sr_op_reg;
    logic [WORD_W-1:0]    rank_pl_reg;
    logic [WORD_W-1:0]    rank_op_reg;
    logic [WORD_W-1:0]    base_reg;
    logic [WORD_W-1:0]    state_rank_reg;

    logic                 load_item;
    logic                 scan_step;
    logic                 mul_step;
    logic                 deliver;

    logic [POS_W-1:0]     n_cells;
    logic [POS_W:0]       base_diff;
    logic                 base_hit;
    logic [ROW_STRIDE-1:0] row_pl;
    logic [ROW_STRIDE-1:0] row_op;
    logic                 cell_pl;
    logic                 cell_op;
    logic                 op_take;
    logic                 last_col;

    row_ctrl_t            pl_row_ctrl;
    row_ctrl_t            op_row_ctrl;
    logic [WORD_W-1:0]    pl_binom;
    logic [WORD_W-1:0]    pl_base_binom;
    logic [WORD_W-1:0]    op_binom;
    logic [WORD_W-1:0]    pl_term;
    logic [WORD_W-1:0]    op_term;
    logic [WORD_W+DIGIT_W-1:0] partial;

    assign n_cells = POS_W'(board_dim_reg) * POS_W'(board_dim_reg);

    // The base multiplier C(N - piece_count, piece_count) is picked off the
    // player's Pascal row as the scan passes position N - piece_count. With no
    // pieces it is one; with fewer cells than pieces it stays zero.
    assign base_diff = {1'b0, n_cells} - (POS_W + 1)'(piece_count_reg);
    assign base_hit  = scan_step && !base_diff[POS_W] && (piece_count_reg != '0)
                       && (pos_reg == base_diff[POS_W-1:0]);

    assign row_pl   = sr_pl_reg[ROW_STRIDE-1:0];
    assign row_op   = sr_op_reg[ROW_STRIDE-1:0];
    assign cell_pl  = row_pl[col_reg];
    assign cell_op  = row_op[col_reg];
    assign last_col = (col_reg == board_dim_reg - DIM_W'(1));

    // An opponent cell whose relabelled position already holds an earlier
    // opponent cell merges with it and takes no ordinal of its own. The
    // relabelled position moves on only past a cell free of player pieces, so
    // the mark survives any run of player cells.
    assign op_take = cell_op && !op_merge_reg;

    // The player's row tracks the dense position; the opponent's row tracks
    // the relabelled position, which moves on only past cells free of player
    // pieces.
    assign pl_row_ctrl.clear   = load_item;
    assign pl_row_ctrl.advance = scan_step;
    assign op_row_ctrl.clear   = load_item;
    assign op_row_ctrl.advance = scan_step && !cell_pl;

    tscr_pascal_row u_pl_row (
        .clk         (clk),
        .ctrl        (pl_row_ctrl),
        .sel_a_k     (ord_pl_reg),
        .sel_a_value (pl_binom),
        .sel_b_k     (ORD_W'(piece_count_reg)),
        .sel_b_value (pl_base_binom)
    );

    tscr_pascal_row u_op_row (
        .clk         (clk),
        .ctrl        (op_row_ctrl),
        .sel_a_k     (ord_op_reg),
        .sel_a_value (op_binom),
        .sel_b_k     (ORD_W'(piece_count_reg)),
        .sel_b_value ()
    );

    // Ordinals above piece_count contribute nothing.
    assign pl_term = (ord_pl_reg <= ORD_W'(piece_count_reg)) ? pl_binom : '0;
    assign op_term = (ord_op_reg <= ORD_W'(piece_count_reg)) ? op_binom : '0;

    // One byte of the base multiplier per step; the multiplicand shifts up.
    assign partial = rank_pl_reg * base_reg[DIGIT_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        load_item  = 1'b0;
        scan_step  = 1'b0;
        mul_step   = 1'b0;
        deliver    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    load_item  = 1'b1;
                    state_next = (n_cells == '0) ? ST_MULT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_step = 1'b1;
                if (pos_reg == n_cells - POS_W'(1))
                begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                mul_step = 1'b1;
                if (mul_cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    deliver    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The user writes configuration only while idle; the block never checks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_dim_reg   <= DIM_W'(MAX_DIM);
            piece_count_reg <= PC_W'(MAX_PIECES);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BOARD_DIM:   board_dim_reg   <= cfg_data[DIM_W-1:0];
                CFG_PIECE_COUNT: piece_count_reg <= cfg_data[PC_W-1:0];
                default:         board_dim_reg   <= board_dim_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            col_reg       <= '0;
            ord_pl_reg    <= ORD_W'(1);
            ord_op_reg    <= ORD_W'(1);
            op_merge_reg  <= 1'b0;
            mul_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_item)
            begin
                pos_reg      <= '0;
                col_reg      <= '0;
                ord_pl_reg   <= ORD_W'(1);
                ord_op_reg   <= ORD_W'(1);
                op_merge_reg <= 1'b0;
                mul_cnt_reg  <= '0;
            end
            else if (scan_step)
            begin
                pos_reg      <= pos_reg + POS_W'(1);
                col_reg      <= last_col ? '0 : col_reg + COL_W'(1);
                op_merge_reg <= cell_pl && (op_merge_reg || cell_op);
                // Ordinals saturate one past the top of the row, which
                // already reads as zero.
                if (cell_pl && (ord_pl_reg != ORD_W'(MAX_PIECES + 1)))
                begin
                    ord_pl_reg <= ord_pl_reg + ORD_W'(1);
                end
                if (op_take && (ord_op_reg != ORD_W'(MAX_PIECES + 1)))
                begin
                    ord_op_reg <= ord_op_reg + ORD_W'(1);
                end
            end
            else if (mul_step)
            begin
                mul_cnt_reg <= mul_cnt_reg + MUL_CNT_W'(1);
            end

            if (deliver)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            sr_pl_reg   <= player_board[WORD_W-1:BOARD_ORIGIN];
            sr_op_reg   <= opponent_board[WORD_W-1:BOARD_ORIGIN];
            rank_pl_reg <= '0;
            rank_op_reg <= '0;
            base_reg    <= (piece_count_reg == '0) ? WORD_W'(1) : '0;
        end
        else if (scan_step)
        begin
            if (last_col)
            begin
                sr_pl_reg <= sr_pl_reg >> ROW_STRIDE;
                sr_op_reg <= sr_op_reg >> ROW_STRIDE;
            end
            if (cell_pl)
            begin
                rank_pl_reg <= rank_pl_reg + pl_term;
            end
            if (op_take)
            begin
                rank_op_reg <= rank_op_reg + op_term;
            end
            if (base_hit)
            begin
                base_reg <= pl_base_binom;
            end
        end
        else if (mul_step)
        begin
            rank_op_reg <= rank_op_reg + partial[WORD_W-1:0];
            rank_pl_reg <= rank_pl_reg << DIGIT_W;
            base_reg    <= base_reg >> DIGIT_W;
        end

        if (deliver)
        begin
            state_rank_reg <= rank_op_reg;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign state_rank = state_rank_reg;

endmodule

`default_nettype wire

[rtl/tscr_pascal_row.sv]
`default_nettype none

// One row of Pascal's triangle, C(n, 0) .. C(n, MAX_PIECES), stepped to n + 1
// on each advance. Ordinals above MAX_PIECES read as zero.
module tscr_pascal_row (
    input  wire logic                        clk,
    input  wire tscr_pkg::row_ctrl_t         ctrl,
    input  wire logic [tscr_pkg::ORD_W-1:0]  sel_a_k,
    output logic      [tscr_pkg::WORD_W-1:0] sel_a_value,
    input  wire logic [tscr_pkg::ORD_W-1:0]  sel_b_k,
    output logic      [tscr_pkg::WORD_W-1:0] sel_b_value
);
    import tscr_pkg::*;

    logic [WORD_W-1:0] row_reg  [0:MAX_PIECES];
    logic [WORD_W-1:0] row_next [0:MAX_PIECES];

    always_comb
    begin
        for (int k = 0; k <= MAX_PIECES; k++)
        begin
            row_next[k] = row_reg[k];
        end
        if (ctrl.clear)
        begin
            row_next[0] = WORD_W'(1);
            for (int k = 1; k <= MAX_PIECES; k++)
            begin
                row_next[k] = '0;
            end
        end
        else if (ctrl.advance)
        begin
            for (int k = 1; k <= MAX_PIECES; k++)
            begin
                row_next[k] = row_reg[k] + row_reg[k - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= MAX_PIECES; k++)
        begin
            row_reg[k] <= row_next[k];
        end
    end

    assign sel_a_value = (sel_a_k <= ORD_W'(MAX_PIECES)) ? row_reg[sel_a_k] : '0;
    assign sel_b_value = (sel_b_k <= ORD_W'(MAX_PIECES)) ? row_reg[sel_b_k] : '0;

endmodule

`default_nettype wire

[verif/combinadic_rank_checker.sv]
`default_nettype none

module combinadic_rank_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire tscr_pkg::cfg_index_t             cfg_index,
    input  wire logic [tscr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             in_valid,
    input  wire logic                             in_ready,
    input  wire logic [tscr_pkg::WORD_W-1:0]      player_board,
    input  wire logic [tscr_pkg::WORD_W-1:0]      opponent_board,
    input  wire logic                             out_valid,
    input  wire logic                             out_ready,
    input  wire logic [tscr_pkg::WORD_W-1:0]      state_rank,
    output int                                    mismatch_count,
    output int                                    ranks_outstanding
);
    import tscr_pkg::*;

    localparam int CELLS = MAX_DIM * MAX_DIM;

    logic [WORD_W-1:0] pascal [0:CELLS][0:MAX_PIECES];
    logic [WORD_W-1:0] expected_ranks [$];
    logic [DIM_W-1:0]  dim_reg;
    logic [PC_W-1:0]   pieces_reg;
    logic [WORD_W-1:0] oldest;

    initial
    begin
        mismatch_count = 0;
        ranks_outstanding = 0;
        for (int n = 0; n <= CELLS; n++)
        begin
            for (int k = 0; k <= MAX_PIECES; k++)
            begin
                if (k == 0)
                    pascal[n][k] = WORD_W'(1);
                else if (k > n)
                    pascal[n][k] = '0;
                else
                    pascal[n][k] = pascal[n-1][k-1] + pascal[n-1][k];
            end
        end
    end

    // Binomials with an ordinal above the configured piece count read as zero.
    function automatic logic [WORD_W-1:0] binomial(int n, int k);
        if (n < 0 || n > CELLS || k < 0 || k > MAX_PIECES || k > n || k > int'(pieces_reg))
            return '0;
        return pascal[n][k];
    endfunction

    function automatic logic [WORD_W-1:0] pack_cells(logic [WORD_W-1:0] board);
        logic [WORD_W-1:0] packed_cells;
        int d;
        packed_cells = '0;
        d = int'(dim_reg);
        for (int i = 0; i < d; i++)
            for (int j = 0; j < d; j++)
                packed_cells[i*d + j] = board[BOARD_ORIGIN + ROW_STRIDE*i + j];
        return packed_cells;
    endfunction

    function automatic logic [WORD_W-1:0] rank_cells(logic [WORD_W-1:0] cells);
        logic [WORD_W-1:0] rank;
        int ordinal;
        rank = '0;
        ordinal = 1;
        for (int pos = 0; pos < CELLS; pos++)
        begin
            if (cells[pos])
            begin
                rank += binomial(pos, ordinal);
                ordinal++;
            end
        end
        return rank;
    endfunction

    // Each cell moves down by the number of taken cells below it; collisions merge.
    function automatic logic [WORD_W-1:0] skip_taken(logic [WORD_W-1:0] cells,
                                                     logic [WORD_W-1:0] taken);
        logic [WORD_W-1:0] moved;
        int below;
        moved = '0;
        for (int pos = 0; pos < CELLS; pos++)
        begin
            if (cells[pos])
            begin
                below = 0;
                for (int q = 0; q < pos; q++)
                    below += int'(taken[q]);
                moved[pos - below] = 1'b1;
            end
        end
        return moved;
    endfunction

    function automatic logic [WORD_W-1:0] predict_state_rank(logic [WORD_W-1:0] player,
                                                             logic [WORD_W-1:0] opponent);
        logic [WORD_W-1:0] own;
        logic [WORD_W-1:0] rival;
        logic [WORD_W-1:0] base;
        int n_cells;
        own = pack_cells(player);
        rival = pack_cells(opponent);
        n_cells = int'(dim_reg) * int'(dim_reg);
        base = '0;
        if (n_cells >= int'(pieces_reg))
            base = binomial(n_cells - int'(pieces_reg), int'(pieces_reg));
        return rank_cells(own) * base + rank_cells(skip_taken(rival, own));
    endfunction

    task automatic note_mismatch(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] state_rank %s: expected %h, got %h", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg = DIM_W'(MAX_DIM);
            pieces_reg = PC_W'(MAX_PIECES);
            expected_ranks.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_ranks.size() == 0)
                    note_mismatch("with nothing outstanding", '0, state_rank);
                else
                begin
                    oldest = expected_ranks.pop_front();
                    if (state_rank !== oldest)
                        note_mismatch("mismatch", oldest, state_rank);
                end
            end
            if (in_valid && in_ready)
                expected_ranks.push_back(predict_state_rank(player_board, opponent_board));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BOARD_DIM:   dim_reg = cfg_data[DIM_W-1:0];
                    CFG_PIECE_COUNT: pieces_reg = cfg_data[PC_W-1:0];
                    default:         ;
                endcase
            end
        end
        ranks_outstanding = expected_ranks.size();
    end

endmodule

`default_nettype wire

[verif/tb_two_set_combinadic_ranker.sv]
`default_nettype none

// Stimulus and verdict for the two-set combinadic ranker. The checker beside
// the block watches every transfer, predicts each state_rank and counts
// mismatches; this module only drives the block and decides pass or fail.
module tb_two_set_combinadic_ranker;
    import tscr_pkg::*;

    // The limit leaves a wide margin over a 7x7 item and over the longest receiver
    // or sender stall at 76% idling.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int PHASES         = 13;

    // Board settings visited by the random part, with the number of items each.
    // They cover the smallest and largest boards, a zero board, no pieces,
    // piece counts beyond MAX_PIECES, and more pieces than the board has cells.
    int phase_dim   [PHASES] = '{7, 1, 0,  2,   7,   3,   4,   5,   6,  7,   7,   7,  2};
    int phase_pc    [PHASES] = '{10, 0, 5, 10,  15,   3,   8,   6,   9,  0,   1,  10,  2};
    int phase_items [PHASES] = '{300, 40, 30, 60, 100, 150, 150, 200, 250, 60, 100, 250, 60};

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    cfg_index_t             cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [WORD_W-1:0]      player_board;
    logic [WORD_W-1:0]      opponent_board;
    logic                   out_valid;
    logic                   out_ready;
    logic [WORD_W-1:0]      state_rank;

    int mismatch_count;
    int ranks_outstanding;
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int quiet_cycles;
    int cur_dim;
    int cur_pc;

    always #5 clk = ~clk;

    two_set_combinadic_ranker DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .player_board   (player_board),
        .opponent_board (opponent_board),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .state_rank     (state_rank)
    );

    combinadic_rank_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .player_board      (player_board),
        .opponent_board    (opponent_board),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .state_rank        (state_rank),
        .mismatch_count    (mismatch_count),
        .ranks_outstanding (ranks_outstanding)
    );

    // The receiver decides anew at every falling edge whether to take a result.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // The watchdog counts cycles in which neither channel completes a transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Bit position of dense cell c on a board of side d in the sparse layout.
    function automatic int sparse_bit(int c, int d);
        return BOARD_ORIGIN + ROW_STRIDE * (c / d) + (c % d);
    endfunction

    function automatic logic [WORD_W-1:0] board_area(int d);
        logic [WORD_W-1:0] area;
        area = '0;
        for (int c = 0; c < d * d; c++)
            area[sparse_bit(c, d)] = 1'b1;
        return area;
    endfunction

    // Places up to count distinct pieces at random on the board, keeping clear
    // of the cells in avoid.
    function automatic logic [WORD_W-1:0] place_pieces(int d, int count,
                                                       logic [WORD_W-1:0] avoid);
        int free_cells [MAX_DIM*MAX_DIM];
        int n_free;
        int pick;
        logic [WORD_W-1:0] board;
        board = '0;
        n_free = 0;
        for (int c = 0; c < d * d; c++)
        begin
            if (!avoid[sparse_bit(c, d)])
            begin
                free_cells[n_free] = c;
                n_free++;
            end
        end
        for (int placed = 0; placed < count && n_free > 0; placed++)
        begin
            pick = $urandom_range(n_free - 1);
            board[sparse_bit(free_cells[pick], d)] = 1'b1;
            free_cells[pick] = free_cells[n_free - 1];
            n_free--;
        end
        return board;
    endfunction

    function automatic logic [WORD_W-1:0] noise_word();
        return {$urandom, $urandom};
    endfunction

    // Offers one item and returns at the falling edge after its transfer.
    // The idling mix follows the running item count: first an eager sender with
    // a slow receiver, 17% sender and 76% receiver idling, then the reverse,
    // and finally no idling on either side.
    task automatic send_item(logic [WORD_W-1:0] player, logic [WORD_W-1:0] opponent);
        if (items_sent < 600)
        begin
            send_idle_pct = 17;
            recv_idle_pct = 76;
        end
        else if (items_sent < 1200)
        begin
            send_idle_pct = 76;
            recv_idle_pct = 17;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        player_board   <= player;
        opponent_board <= opponent;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // The sender holds off until every predicted rank has been transferred.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (ranks_outstanding != 0)
            @(negedge clk);
    endtask

    // Writes both registers on consecutive cycles. The spare top data bit of
    // the board_dim write is random, since only the low three bits count.
    task automatic set_board(int dim, int pc);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BOARD_DIM;
        cfg_data  <= {1'($urandom_range(1)), 3'(dim)};
        @(negedge clk);
        cfg_index <= CFG_PIECE_COUNT;
        cfg_data  <= 4'(pc);
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_dim = dim;
        cur_pc  = pc;
    endtask

    // Mostly legal positions with at most piece_count pieces per side and no
    // shared cells; the rest has overlaps, too many pieces, stray bits outside
    // the board, or plain noise across all 64 bits.
    task automatic random_position(output logic [WORD_W-1:0] player,
                                   output logic [WORD_W-1:0] opponent);
        int n_cells;
        int cap;
        int pick;
        n_cells = cur_dim * cur_dim;
        cap = (cur_pc < n_cells) ? cur_pc : n_cells;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            player   = place_pieces(cur_dim, $urandom_range(cap), '0);
            opponent = place_pieces(cur_dim, $urandom_range(cap), player);
        end
        else if (pick < 70)
        begin
            player   = place_pieces(cur_dim, $urandom_range(n_cells), '0);
            opponent = place_pieces(cur_dim, $urandom_range(n_cells), '0);
        end
        else if (pick < 80)
        begin
            player   = place_pieces(cur_dim, $urandom_range(cap), '0);
            opponent = place_pieces(cur_dim, $urandom_range(cap), player);
            player   |= noise_word() & ~board_area(cur_dim);
            opponent |= noise_word() & ~board_area(cur_dim);
        end
        else
        begin
            player   = noise_word();
            opponent = noise_word();
        end
    endtask

    // Directed positions on the reset board (7x7, ten pieces): empty and full
    // boards, bits only outside the board, each corner, whole rows, checker
    // patterns, shared cells and exactly ten pieces per side.
    task automatic directed_positions();
        logic [WORD_W-1:0] area;
        logic [WORD_W-1:0] ten_a;
        logic [WORD_W-1:0] ten_b;
        area  = board_area(MAX_DIM);
        ten_a = place_pieces(MAX_DIM, MAX_PIECES, '0);
        ten_b = place_pieces(MAX_DIM, MAX_PIECES, ten_a);
        send_item('0, '0);
        send_item('1, '1);
        send_item(area, '0);
        send_item('0, area);
        send_item(~area, ~area);
        send_item(64'd1 << 9, 64'd1 << 63);
        send_item(64'd1 << 63, 64'd1 << 9);
        send_item(64'd1 << 15, 64'd1 << 57);
        send_item(64'h7F << 9, 64'h7F << 57);
        send_item(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_item(area & 64'hAAAA_AAAA_AAAA_AAAA, area & 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(ten_a, ten_b);
        send_item(ten_b, ten_a);
        send_item(ten_a, ten_a | ten_b);
    endtask

    initial
    begin
        logic [WORD_W-1:0] player;
        logic [WORD_W-1:0] opponent;

        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_BOARD_DIM;
        cfg_data       = '0;
        in_valid       = 1'b0;
        out_ready      = 1'b0;
        player_board   = '0;
        opponent_board = '0;
        send_idle_pct  = 17;
        recv_idle_pct  = 76;
        items_sent     = 0;
        quiet_cycles   = 0;
        cur_dim        = MAX_DIM;
        cur_pc         = MAX_PIECES;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        directed_positions();

        // Every phase starts from an idle block: the sender drains all
        // outstanding ranks before the registers are rewritten.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            set_board(phase_dim[p], phase_pc[p]);
            for (int i = 0; i < phase_items[p]; i++)
            begin
                random_position(player, opponent);
                send_item(player, opponent);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
